FILE: rtl/expression_token_lexer_top_assert.svh
// Assertion macros for the lexer RTL.
// Every macro samples on the rising edge of clock and is off during reset.
`ifndef EXPRESSION_TOKEN_LEXER_TOP_ASSERT_SVH
`define EXPRESSION_TOKEN_LEXER_TOP_ASSERT_SVH

// A property that must hold at every sampled edge.
`define ETL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define ETL_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/etl_pkg.sv
package etl_pkg;

   // One result word of the lexer.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       has_byte;
      logic       token_last;
      logic [4:0] token_kind;
      logic [1:0] error_code;
   } result_type;

   // The most result words that one input word can cause.
   localparam int MaxWords = 3;

   // All words caused by one input word, in order from words[0].
   typedef struct packed {
      logic [1:0]                  count;
      result_type [MaxWords-1:0]   words;
   } step_out_type;

   // Token kinds.
   localparam logic [4:0] KIND_NONE   = 5'd0;  // kind field of a word that does not close a token
   localparam logic [4:0] KIND_END    = 5'd0;
   localparam logic [4:0] KIND_IDENT  = 5'd1;
   localparam logic [4:0] KIND_INT    = 5'd2;
   localparam logic [4:0] KIND_FLOAT  = 5'd3;
   localparam logic [4:0] KIND_STRING = 5'd4;
   localparam logic [4:0] KIND_LPAREN = 5'd5;
   localparam logic [4:0] KIND_RPAREN = 5'd6;
   localparam logic [4:0] KIND_LBRACK = 5'd7;
   localparam logic [4:0] KIND_RBRACK = 5'd8;
   localparam logic [4:0] KIND_DOT    = 5'd9;
   localparam logic [4:0] KIND_SCOPE  = 5'd10;
   localparam logic [4:0] KIND_PLUS   = 5'd11;
   localparam logic [4:0] KIND_MINUS  = 5'd12;
   localparam logic [4:0] KIND_STAR   = 5'd13;
   localparam logic [4:0] KIND_SLASH  = 5'd14;
   localparam logic [4:0] KIND_PCT    = 5'd15;
   localparam logic [4:0] KIND_NOT    = 5'd16;
   localparam logic [4:0] KIND_NE     = 5'd17;
   localparam logic [4:0] KIND_LT     = 5'd18;
   localparam logic [4:0] KIND_LE     = 5'd19;
   localparam logic [4:0] KIND_GT     = 5'd20;
   localparam logic [4:0] KIND_GE     = 5'd21;
   localparam logic [4:0] KIND_EQ     = 5'd22;
   localparam logic [4:0] KIND_ASSIGN = 5'd23;
   localparam logic [4:0] KIND_AND    = 5'd24;
   localparam logic [4:0] KIND_OR     = 5'd25;

   // Error codes.
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_CHAR   = 2'd1;
   localparam logic [1:0] ERR_STRING = 2'd2;

endpackage

FILE: rtl/etl_channels.sv
// Input channel: one source byte or an end marker per word.
interface etl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       is_end;

   modport source (output valid, char_code, is_end, input ready);
   modport sink   (input valid, char_code, is_end, output ready);
endinterface

// Result channel: one token text byte, terminator or error per word.
interface etl_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       has_byte;
   logic       token_last;
   logic [4:0] token_kind;
   logic [1:0] error_code;

   modport source (output valid, text_byte, has_byte, token_last, token_kind, error_code,
                   input ready);
   modport sink   (input valid, text_byte, has_byte, token_last, token_kind, error_code,
                   output ready);
endinterface

FILE: rtl/etl_step.sv
module etl_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            char_code,
   input  logic                  is_end,
   output etl_pkg::step_out_type step_out
);

   localparam logic [3:0] MODE_IDLE   = 4'd0;
   localparam logic [3:0] MODE_IDENT  = 4'd1;
   localparam logic [3:0] MODE_INT    = 4'd2;
   localparam logic [3:0] MODE_INTDOT = 4'd3;
   localparam logic [3:0] MODE_FRAC   = 4'd4;
   localparam logic [3:0] MODE_STR    = 4'd5;
   localparam logic [3:0] MODE_STRESC = 4'd6;
   localparam logic [3:0] MODE_OPHELD = 4'd7;
   localparam logic [3:0] MODE_ERROR  = 4'd8;

   // Outcome of a byte seen between tokens.
   typedef struct packed {
      logic [3:0]           mode;
      logic [7:0]           held;
      logic                 emit;
      etl_pkg::result_type  word;
   } start_type;

   // Outcome of settling a held operator against the byte after it.
   typedef struct packed {
      logic                 consumed;
      logic [3:0]           mode;
      logic [1:0]           count;
      etl_pkg::result_type  word0;
      etl_pkg::result_type  word1;
   } resolve_type;

   logic [3:0] lexer_mode_ff, lexer_mode_in;
   logic [7:0] held_operator_ff, held_operator_in;

   function automatic etl_pkg::result_type make_word(input logic [7:0] b, input logic has,
                                                     input logic last, input logic [4:0] kind,
                                                     input logic [1:0] err);
      etl_pkg::result_type w;
      w.text_byte  = b;
      w.has_byte   = has;
      w.token_last = last;
      w.token_kind = kind;
      w.error_code = err;
      return w;
   endfunction

   function automatic etl_pkg::result_type text_word(input logic [7:0] b);
      return make_word(b, 1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_NONE);
   endfunction

   function automatic etl_pkg::result_type op_word(input logic [7:0] b, input logic [4:0] kind);
      return make_word(b, 1'b1, 1'b1, kind, etl_pkg::ERR_NONE);
   endfunction

   function automatic etl_pkg::result_type term_word(input logic [4:0] kind);
      return make_word(8'h00, 1'b0, 1'b1, kind, etl_pkg::ERR_NONE);
   endfunction

   function automatic etl_pkg::result_type err_word(input logic [7:0] b, input logic has,
                                                    input logic [1:0] err);
      return make_word(b, has, 1'b0, etl_pkg::KIND_NONE, err);
   endfunction

   // Character classes, C locale.
   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'h20, [8'h09:8'h0D]};
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == "_");
   endfunction

   function automatic logic [7:0] unescape(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         "n":     r = 8'd10;
         "r":     r = 8'd13;
         "t":     r = 8'd9;
         default: r = c;
      endcase
      return r;
   endfunction

   // A byte that opens a token, starts an operator, is dropped or is an error.
   function automatic start_type start_token(input logic [7:0] c);
      start_type s;
      s.mode = MODE_IDLE;
      s.held = 8'h00;
      s.emit = 1'b0;
      s.word = text_word(c);
      if (is_space(c)) begin
         s.mode = MODE_IDLE;
      end else if (is_alpha(c) || (c == "_")) begin
         s.emit = 1'b1;
         s.mode = MODE_IDENT;
      end else if (is_digit(c)) begin
         s.emit = 1'b1;
         s.mode = MODE_INT;
      end else begin
         case (c)
            "\"": s.mode = MODE_STR;
            "(": begin
               s.emit = 1'b1;
               s.word = op_word(c, etl_pkg::KIND_LPAREN);
            end
            ")": begin
               s.emit = 1'b1;
               s.word = op_word(c, etl_pkg::KIND_RPAREN);
            end
            "[": begin
               s.emit = 1'b1;
               s.word = op_word(c, etl_pkg::KIND_LBRACK);
            end
            "]": begin
               s.emit = 1'b1;
               s.word = op_word(c, etl_pkg::KIND_RBRACK);
            end
            ".": begin
               s.emit = 1'b1;
               s.word = op_word(c, etl_pkg::KIND_DOT);
            end
            ":", "+", "-", "*", "/", "%", "!", "<", ">", "=", "&", "|": begin
               s.held = c;
               s.mode = MODE_OPHELD;
            end
            default: begin
               s.emit = 1'b1;
               s.word = err_word(c, 1'b1, etl_pkg::ERR_CHAR);
               s.mode = MODE_ERROR;
            end
         endcase
      end
      return s;
   endfunction

   // Settle the held operator h against byte n; has_next is low at an end marker.
   function automatic resolve_type resolve_op(input logic [7:0] h, input logic [7:0] n,
                                              input logic has_next);
      resolve_type r;
      logic        doubled;
      logic        arith;
      logic [4:0]  single;
      logic [4:0]  pair;
      r.consumed = 1'b0;
      r.mode     = MODE_IDLE;
      r.count    = 2'd0;
      r.word0    = text_word(h);
      r.word1    = text_word(n);
      doubled    = 1'b0;
      arith      = 1'b0;
      single     = etl_pkg::KIND_NONE;
      pair       = etl_pkg::KIND_NONE;
      case (h)
         ":": begin doubled = 1'b1; pair = etl_pkg::KIND_SCOPE; end
         "&": begin doubled = 1'b1; pair = etl_pkg::KIND_AND; end
         "|": begin doubled = 1'b1; pair = etl_pkg::KIND_OR; end
         "+": begin arith = 1'b1; single = etl_pkg::KIND_PLUS;   pair = etl_pkg::KIND_ASSIGN; end
         "-": begin arith = 1'b1; single = etl_pkg::KIND_MINUS;  pair = etl_pkg::KIND_ASSIGN; end
         "*": begin arith = 1'b1; single = etl_pkg::KIND_STAR;   pair = etl_pkg::KIND_ASSIGN; end
         "/": begin arith = 1'b1; single = etl_pkg::KIND_SLASH;  pair = etl_pkg::KIND_ASSIGN; end
         "%": begin arith = 1'b1; single = etl_pkg::KIND_PCT;    pair = etl_pkg::KIND_ASSIGN; end
         "!": begin arith = 1'b1; single = etl_pkg::KIND_NOT;    pair = etl_pkg::KIND_NE; end
         "<": begin arith = 1'b1; single = etl_pkg::KIND_LT;     pair = etl_pkg::KIND_LE; end
         ">": begin arith = 1'b1; single = etl_pkg::KIND_GT;     pair = etl_pkg::KIND_GE; end
         "=": begin arith = 1'b1; single = etl_pkg::KIND_ASSIGN; pair = etl_pkg::KIND_EQ; end
         default: ;
      endcase
      if (doubled) begin
         // These operators only exist doubled; a lone one is an error.
         if (has_next && (n == h)) begin
            r.consumed = 1'b1;
            r.count    = 2'd2;
            r.word1    = op_word(h, pair);
         end else begin
            r.count = 2'd1;
            r.word0 = err_word(h, 1'b1, etl_pkg::ERR_CHAR);
            r.mode  = MODE_ERROR;
         end
      end else if (arith) begin
         if (has_next && (n == "=")) begin
            r.consumed = 1'b1;
            r.count    = 2'd2;
            r.word1    = op_word(n, pair);
         end else begin
            r.count = 2'd1;
            r.word0 = op_word(h, single);
         end
      end
      return r;
   endfunction

   // Next state and result words for the byte on the input.
   always_comb begin
      start_type   st;
      resolve_type ro;
      st = start_token(char_code);
      ro = resolve_op(held_operator_ff, char_code, !is_end);
      step_out.count    = 2'd0;
      step_out.words    = '0;
      lexer_mode_in     = lexer_mode_ff;
      held_operator_in  = held_operator_ff;

      if (is_end) begin
         // Flush what is pending, then always close with the end token.
         lexer_mode_in    = MODE_IDLE;
         held_operator_in = 8'h00;
         case (lexer_mode_ff)
            MODE_IDENT: begin
               step_out.words[0] = term_word(etl_pkg::KIND_IDENT);
               step_out.words[1] = term_word(etl_pkg::KIND_END);
               step_out.count    = 2'd2;
            end
            MODE_INT: begin
               step_out.words[0] = term_word(etl_pkg::KIND_INT);
               step_out.words[1] = term_word(etl_pkg::KIND_END);
               step_out.count    = 2'd2;
            end
            MODE_INTDOT: begin
               step_out.words[0] = term_word(etl_pkg::KIND_INT);
               step_out.words[1] = op_word(".", etl_pkg::KIND_DOT);
               step_out.words[2] = term_word(etl_pkg::KIND_END);
               step_out.count    = 2'd3;
            end
            MODE_FRAC: begin
               step_out.words[0] = term_word(etl_pkg::KIND_FLOAT);
               step_out.words[1] = term_word(etl_pkg::KIND_END);
               step_out.count    = 2'd2;
            end
            MODE_STR, MODE_STRESC: begin
               step_out.words[0] = err_word(8'h00, 1'b0, etl_pkg::ERR_STRING);
               step_out.words[1] = term_word(etl_pkg::KIND_END);
               step_out.count    = 2'd2;
            end
            MODE_OPHELD: begin
               step_out.words[0] = ro.word0;
               step_out.words[1] = term_word(etl_pkg::KIND_END);
               step_out.count    = 2'd2;
            end
            default: begin
               step_out.words[0] = term_word(etl_pkg::KIND_END);
               step_out.count    = 2'd1;
            end
         endcase
      end else begin
         case (lexer_mode_ff)
            MODE_IDENT: begin
               if (is_word(char_code)) begin
                  step_out.words[0] = text_word(char_code);
                  step_out.count    = 2'd1;
               end else begin
                  step_out.words[0] = term_word(etl_pkg::KIND_IDENT);
                  step_out.words[1] = st.word;
                  step_out.count    = st.emit ? 2'd2 : 2'd1;
                  lexer_mode_in     = st.mode;
                  held_operator_in  = st.held;
               end
            end
            MODE_INT: begin
               if (is_digit(char_code)) begin
                  step_out.words[0] = text_word(char_code);
                  step_out.count    = 2'd1;
               end else if (char_code == ".") begin
                  lexer_mode_in = MODE_INTDOT;
               end else begin
                  step_out.words[0] = term_word(etl_pkg::KIND_INT);
                  step_out.words[1] = st.word;
                  step_out.count    = st.emit ? 2'd2 : 2'd1;
                  lexer_mode_in     = st.mode;
                  held_operator_in  = st.held;
               end
            end
            MODE_INTDOT: begin
               // The held dot becomes part of a float or a dot operator.
               if (is_digit(char_code)) begin
                  step_out.words[0] = text_word(".");
                  step_out.words[1] = text_word(char_code);
                  step_out.count    = 2'd2;
                  lexer_mode_in     = MODE_FRAC;
               end else begin
                  step_out.words[0] = term_word(etl_pkg::KIND_INT);
                  step_out.words[1] = op_word(".", etl_pkg::KIND_DOT);
                  step_out.words[2] = st.word;
                  step_out.count    = st.emit ? 2'd3 : 2'd2;
                  lexer_mode_in     = st.mode;
                  held_operator_in  = st.held;
               end
            end
            MODE_FRAC: begin
               if (is_digit(char_code)) begin
                  step_out.words[0] = text_word(char_code);
                  step_out.count    = 2'd1;
               end else begin
                  step_out.words[0] = term_word(etl_pkg::KIND_FLOAT);
                  step_out.words[1] = st.word;
                  step_out.count    = st.emit ? 2'd2 : 2'd1;
                  lexer_mode_in     = st.mode;
                  held_operator_in  = st.held;
               end
            end
            MODE_STR: begin
               if (char_code == "\\") begin
                  lexer_mode_in = MODE_STRESC;
               end else if (char_code == "\"") begin
                  step_out.words[0] = term_word(etl_pkg::KIND_STRING);
                  step_out.count    = 2'd1;
                  lexer_mode_in     = MODE_IDLE;
               end else begin
                  step_out.words[0] = text_word(char_code);
                  step_out.count    = 2'd1;
               end
            end
            MODE_STRESC: begin
               step_out.words[0] = text_word(unescape(char_code));
               step_out.count    = 2'd1;
               lexer_mode_in     = MODE_STR;
            end
            MODE_OPHELD: begin
               step_out.words[0] = ro.word0;
               step_out.words[1] = ro.word1;
               step_out.count    = ro.count;
               lexer_mode_in     = ro.mode;
               held_operator_in  = 8'h00;
               // A byte not taken as second character starts the next token, unless the held operator is an error.
               if (!ro.consumed && (ro.mode != MODE_ERROR)) begin
                  step_out.words[1] = st.word;
                  step_out.count    = st.emit ? 2'd2 : 2'd1;
                  lexer_mode_in     = st.mode;
                  held_operator_in  = st.held;
               end
            end
            MODE_ERROR: ;
            default: begin
               step_out.words[0] = st.word;
               step_out.count    = st.emit ? 2'd1 : 2'd0;
               lexer_mode_in     = st.mode;
               held_operator_in  = st.held;
            end
         endcase
      end
   end

   // Lexer state advances once per accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         lexer_mode_ff    <= MODE_IDLE;
         held_operator_ff <= 8'h00;
      end else if (accept) begin
         lexer_mode_ff    <= lexer_mode_in;
         held_operator_ff <= held_operator_in;
      end
   end

endmodule

FILE: rtl/etl_out_buf.sv
`include "expression_token_lexer_top_assert.svh"

module etl_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  etl_pkg::step_out_type step_out,
   output logic                  load_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output etl_pkg::result_type   rsp_word
);

   etl_pkg::result_type slot_ff [etl_pkg::MaxWords];
   logic [1:0]          count_ff;
   logic                pop;

   // Head slot drives the result channel.
   assign rsp_valid  = (count_ff != 2'd0);
   assign rsp_word   = slot_ff[0];
   assign pop        = rsp_valid && rsp_ready;

   // A new word may load once the buffer empties in this cycle.
   assign load_ready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);

   // Control: fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (load) begin
         count_ff <= step_out.count;
      end else if (pop) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   // Payload: load all slots at once, shift toward the head on each pop.
   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff[0] <= step_out.words[0];
         slot_ff[1] <= step_out.words[1];
         slot_ff[2] <= step_out.words[2];
      end else if (pop) begin
         slot_ff[0] <= slot_ff[1];
         slot_ff[1] <= slot_ff[2];
      end
   end

   `ETL_ASSERT_ALWAYS(a_no_load_when_busy, (count_ff > 2'd1) |-> !load,
                      "load while buffer busy")
   `ETL_ASSERT_NEXT(a_pop_counts_down, (count_ff > 2'd1) && rsp_ready,
                    count_ff == $past(count_ff) - 2'd1, "pop did not count down")
   `ETL_ASSERT_NEXT(a_empty_load, load && (step_out.count == 2'd0), count_ff == 2'd0,
                    "silent word left buffer busy")

endmodule

FILE: rtl/expression_token_lexer_top.sv
// Expression token lexer.
// The req_channel carries one source byte per word, or an end marker when
// is_end is set. The rsp_channel carries the token stream: one text byte per
// word, byte-less terminators with token_last and token_kind for identifiers,
// numbers and strings, operators closed on their last byte, and error words.
// Latency: the first result of a word appears on rsp_channel the cycle after the
// word is accepted. Throughput: one input word per cycle while each word
// causes at most one result and the receiver takes it; a word that causes k
// results (k up to three) holds req_channel.ready low until only its last result
// waits and is being taken, as the three-slot result buffer has a single read port.
// When the receiver stalls, results stay in the buffer and ready stays low
// while any result waits; no result is lost or repeated.
// Reset (synchronous, active high) returns the lexer to the idle state
// between tokens, clears the held operator and empties the result buffer.
// After an error, bytes are ignored until an end marker, which always
// produces an end token.
module expression_token_lexer_top (
   input  logic      clock,
   input  logic      reset,
   etl_req_if.sink   req_channel,
   etl_rsp_if.source rsp_channel
);

   etl_pkg::step_out_type step_out;
   etl_pkg::result_type   rsp_word;
   logic                  load_ready;
   logic                  accept;

   assign req_channel.ready = load_ready;
   assign accept            = req_channel.valid && load_ready;

   // Decode of the accepted byte against the lexer state.
   etl_step u_step (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_channel.char_code),
      .is_end    (req_channel.is_end),
      .step_out  (step_out)
   );

   // Result buffer toward the receiver.
   etl_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .step_out   (step_out),
      .load_ready (load_ready),
      .rsp_valid  (rsp_channel.valid),
      .rsp_ready  (rsp_channel.ready),
      .rsp_word   (rsp_word)
   );

   assign rsp_channel.text_byte  = rsp_word.text_byte;
   assign rsp_channel.has_byte   = rsp_word.has_byte;
   assign rsp_channel.token_last = rsp_word.token_last;
   assign rsp_channel.token_kind = rsp_word.token_kind;
   assign rsp_channel.error_code = rsp_word.error_code;

endmodule

FILE: sim/testbench.sv
module testbench;

   localparam int RandomItems = 430;
   localparam int CalmTail = 60;
   localparam int QuietLimit = 1000;
   localparam int DrainCycles = 8;
   localparam int DirectedCount = 26;

   // Lexer modes of the predictor.
   localparam logic [3:0] LX_IDLE   = 4'd0;
   localparam logic [3:0] LX_IDENT  = 4'd1;
   localparam logic [3:0] LX_INT    = 4'd2;
   localparam logic [3:0] LX_INTDOT = 4'd3;
   localparam logic [3:0] LX_FRAC   = 4'd4;
   localparam logic [3:0] LX_STR    = 4'd5;
   localparam logic [3:0] LX_STRESC = 4'd6;
   localparam logic [3:0] LX_OPHELD = 4'd7;
   localparam logic [3:0] LX_ERROR  = 4'd8;

   // One directed row: the word to send, and optionally the first result it must cause.
   typedef struct packed {
      logic [7:0]          char_code;
      logic                is_end;
      logic                pinned;
      etl_pkg::result_type first_word;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_end;
   } source_word_type;

   localparam etl_pkg::result_type NoWord = '0;

   localparam stim_row_type DirectedRows[DirectedCount] = '{
      // A NUL byte between tokens is an unexpected character.
      {8'h00, 1'b0, 1'b1, {8'h00, 1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_CHAR}},
      {8'hFF, 1'b0, 1'b0, NoWord},
      {8'h00, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, etl_pkg::KIND_END, etl_pkg::ERR_NONE}},
      // Identifier "_Z9" closed by the scope operator.
      {"_",   1'b0, 1'b1, {"_",   1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_NONE}},
      {"Z",   1'b0, 1'b0, NoWord},
      {"9",   1'b0, 1'b0, NoWord},
      {":",   1'b0, 1'b1, {8'h00, 1'b0, 1'b1, etl_pkg::KIND_IDENT, etl_pkg::ERR_NONE}},
      {":",   1'b0, 1'b0, NoWord},
      // Float "7.0" closed by a carriage return.
      {"7",   1'b0, 1'b0, NoWord},
      {".",   1'b0, 1'b0, NoWord},
      {"0",   1'b0, 1'b0, NoWord},
      {8'h0D, 1'b0, 1'b1, {8'h00, 1'b0, 1'b1, etl_pkg::KIND_FLOAT, etl_pkg::ERR_NONE}},
      // A lone ampersand is an error and the byte after it is dropped.
      {"&",   1'b0, 1'b0, NoWord},
      {"x",   1'b0, 1'b1, {"&",   1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_CHAR}},
      {8'hFF, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, etl_pkg::KIND_END, etl_pkg::ERR_NONE}},
      // Open string with an escape, cut off by the end marker.
      {"\"",  1'b0, 1'b0, NoWord},
      {"\\",  1'b0, 1'b0, NoWord},
      {"n",   1'b0, 1'b1, {8'h0A, 1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_NONE}},
      {8'hFF, 1'b0, 1'b0, NoWord},
      {8'h00, 1'b1, 1'b1, {8'h00, 1'b0, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_STRING}},
      // Integer with a pending dot flushed by end: three results.
      {"3",   1'b0, 1'b0, NoWord},
      {".",   1'b0, 1'b0, NoWord},
      {8'h00, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, etl_pkg::KIND_INT, etl_pkg::ERR_NONE}},
      {"<",   1'b0, 1'b0, NoWord},
      {"=",   1'b0, 1'b0, NoWord},
      {8'h00, 1'b1, 1'b0, NoWord}
   };

   string op_texts[26] = '{
      "(", ")", "[", "]", ".", "::", "+", "-", "*", "/", "%", "!", "!=",
      "<", "<=", ">", ">=", "==", "=", "+=", "-=", "*=", "/=", "%=", "&&", "||"
   };

   logic clock = 1'b0;
   logic reset;

   etl_req_if req_bus ();
   etl_rsp_if rsp_bus ();

   expression_token_lexer_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_bus),
      .rsp_channel (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state and the words it expects.
   logic [3:0]          lex_mode = LX_IDLE;
   logic [7:0]          held_op = 8'h00;
   etl_pkg::result_type step_words[$];
   etl_pkg::result_type expected_words[$];
   source_word_type     random_words[$];

   int failures = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   bit calm = 1'b0;

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   task automatic emit(input logic [7:0] text, input logic has, input logic last,
                       input logic [4:0] kind, input logic [1:0] err);
      etl_pkg::result_type w;
      w.text_byte = text;
      w.has_byte = has;
      w.token_last = last;
      w.token_kind = kind;
      w.error_code = err;
      step_words = {step_words, w};
   endtask

   task automatic reject_char(input logic [7:0] c);
      emit(c, 1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_CHAR);
      lex_mode = LX_ERROR;
      held_op = 8'h00;
   endtask

   // A byte seen between tokens starts a new token, is skipped or is rejected.
   task automatic open_token(input logic [7:0] c);
      lex_mode = LX_IDLE;
      if (is_space(c)) begin
      end else if (is_alpha(c) || c == "_") begin
         emit(c, 1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_NONE);
         lex_mode = LX_IDENT;
      end else if (is_digit(c)) begin
         emit(c, 1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_NONE);
         lex_mode = LX_INT;
      end else begin
         case (c)
            "\"": lex_mode = LX_STR;
            "(": emit(c, 1'b1, 1'b1, etl_pkg::KIND_LPAREN, etl_pkg::ERR_NONE);
            ")": emit(c, 1'b1, 1'b1, etl_pkg::KIND_RPAREN, etl_pkg::ERR_NONE);
            "[": emit(c, 1'b1, 1'b1, etl_pkg::KIND_LBRACK, etl_pkg::ERR_NONE);
            "]": emit(c, 1'b1, 1'b1, etl_pkg::KIND_RBRACK, etl_pkg::ERR_NONE);
            ".": emit(c, 1'b1, 1'b1, etl_pkg::KIND_DOT, etl_pkg::ERR_NONE);
            ":", "+", "-", "*", "/", "%", "!", "<", ">", "=", "&", "|": begin
               held_op = c;
               lex_mode = LX_OPHELD;
            end
            default: reject_char(c);
         endcase
      end
   endtask

   // Settle the held operator against the next byte; has_next is low at end.
   task automatic resolve_held(input logic [7:0] n, input bit has_next, output bit took_next);
      logic [7:0] h;
      logic [4:0] one_kind;
      logic [4:0] two_kind;
      bit         plain_op;
      h = held_op;
      held_op = 8'h00;
      lex_mode = LX_IDLE;
      took_next = 1'b0;
      plain_op = 1'b1;
      one_kind = etl_pkg::KIND_NONE;
      two_kind = etl_pkg::KIND_NONE;
      case (h)
         ":", "&", "|": begin
            plain_op = 1'b0;
            if (has_next && n == h) begin
               two_kind = (h == ":") ? etl_pkg::KIND_SCOPE :
                          (h == "&") ? etl_pkg::KIND_AND : etl_pkg::KIND_OR;
               emit(h, 1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_NONE);
               emit(h, 1'b1, 1'b1, two_kind, etl_pkg::ERR_NONE);
               took_next = 1'b1;
            end else begin
               reject_char(h);
            end
         end
         "+": begin one_kind = etl_pkg::KIND_PLUS;   two_kind = etl_pkg::KIND_ASSIGN; end
         "-": begin one_kind = etl_pkg::KIND_MINUS;  two_kind = etl_pkg::KIND_ASSIGN; end
         "*": begin one_kind = etl_pkg::KIND_STAR;   two_kind = etl_pkg::KIND_ASSIGN; end
         "/": begin one_kind = etl_pkg::KIND_SLASH;  two_kind = etl_pkg::KIND_ASSIGN; end
         "%": begin one_kind = etl_pkg::KIND_PCT;    two_kind = etl_pkg::KIND_ASSIGN; end
         "!": begin one_kind = etl_pkg::KIND_NOT;    two_kind = etl_pkg::KIND_NE;     end
         "<": begin one_kind = etl_pkg::KIND_LT;     two_kind = etl_pkg::KIND_LE;     end
         ">": begin one_kind = etl_pkg::KIND_GT;     two_kind = etl_pkg::KIND_GE;     end
         "=": begin one_kind = etl_pkg::KIND_ASSIGN; two_kind = etl_pkg::KIND_EQ;     end
         default: plain_op = 1'b0;
      endcase
      if (plain_op) begin
         if (has_next && n == "=") begin
            emit(h, 1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_NONE);
            emit("=", 1'b1, 1'b1, two_kind, etl_pkg::ERR_NONE);
            took_next = 1'b1;
         end else begin
            emit(h, 1'b1, 1'b1, one_kind, etl_pkg::ERR_NONE);
         end
      end
   endtask

   // Work out the result words that one accepted word causes.
   task automatic predict_word(input logic [7:0] c, input logic is_end);
      bit took;
      step_words.delete();
      if (is_end) begin
         case (lex_mode)
            LX_IDENT: emit(8'h00, 1'b0, 1'b1, etl_pkg::KIND_IDENT, etl_pkg::ERR_NONE);
            LX_INT: emit(8'h00, 1'b0, 1'b1, etl_pkg::KIND_INT, etl_pkg::ERR_NONE);
            LX_INTDOT: begin
               emit(8'h00, 1'b0, 1'b1, etl_pkg::KIND_INT, etl_pkg::ERR_NONE);
               emit(".", 1'b1, 1'b1, etl_pkg::KIND_DOT, etl_pkg::ERR_NONE);
            end
            LX_FRAC: emit(8'h00, 1'b0, 1'b1, etl_pkg::KIND_FLOAT, etl_pkg::ERR_NONE);
            LX_STR, LX_STRESC: emit(8'h00, 1'b0, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_STRING);
            LX_OPHELD: resolve_held(8'h00, 1'b0, took);
            default: ;
         endcase
         emit(8'h00, 1'b0, 1'b1, etl_pkg::KIND_END, etl_pkg::ERR_NONE);
         lex_mode = LX_IDLE;
         held_op = 8'h00;
      end else begin
         case (lex_mode)
            LX_IDENT: begin
               if (is_alpha(c) || is_digit(c) || c == "_") begin
                  emit(c, 1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_NONE);
               end else begin
                  emit(8'h00, 1'b0, 1'b1, etl_pkg::KIND_IDENT, etl_pkg::ERR_NONE);
                  open_token(c);
               end
            end
            LX_INT: begin
               if (is_digit(c)) begin
                  emit(c, 1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_NONE);
               end else if (c == ".") begin
                  lex_mode = LX_INTDOT;
               end else begin
                  emit(8'h00, 1'b0, 1'b1, etl_pkg::KIND_INT, etl_pkg::ERR_NONE);
                  open_token(c);
               end
            end
            // The dot becomes part of a float only if a digit follows.
            LX_INTDOT: begin
               if (is_digit(c)) begin
                  emit(".", 1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_NONE);
                  emit(c, 1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_NONE);
                  lex_mode = LX_FRAC;
               end else begin
                  emit(8'h00, 1'b0, 1'b1, etl_pkg::KIND_INT, etl_pkg::ERR_NONE);
                  emit(".", 1'b1, 1'b1, etl_pkg::KIND_DOT, etl_pkg::ERR_NONE);
                  open_token(c);
               end
            end
            LX_FRAC: begin
               if (is_digit(c)) begin
                  emit(c, 1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_NONE);
               end else begin
                  emit(8'h00, 1'b0, 1'b1, etl_pkg::KIND_FLOAT, etl_pkg::ERR_NONE);
                  open_token(c);
               end
            end
            LX_STR: begin
               if (c == "\\") begin
                  lex_mode = LX_STRESC;
               end else if (c == "\"") begin
                  emit(8'h00, 1'b0, 1'b1, etl_pkg::KIND_STRING, etl_pkg::ERR_NONE);
                  lex_mode = LX_IDLE;
               end else begin
                  emit(c, 1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_NONE);
               end
            end
            LX_STRESC: begin
               case (c)
                  "n": emit(8'h0A, 1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_NONE);
                  "r": emit(8'h0D, 1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_NONE);
                  "t": emit(8'h09, 1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_NONE);
                  default: emit(c, 1'b1, 1'b0, etl_pkg::KIND_NONE, etl_pkg::ERR_NONE);
               endcase
               lex_mode = LX_STR;
            end
            LX_OPHELD: begin
               resolve_held(c, 1'b1, took);
               if (!took && lex_mode != LX_ERROR) begin
                  open_token(c);
               end
            end
            LX_ERROR: ;
            default: open_token(c);
         endcase
      end
   endtask

   function automatic logic [7:0] random_word_char(input bit lead);
      int r;
      r = int'($urandom_range(0, lead ? 52 : 62));
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r == 52) return "_";
      return 8'("0" + r - 53);
   endfunction

   task automatic queue_word(input logic [7:0] c, input logic is_end);
      source_word_type w;
      w.char_code = c;
      w.is_end = is_end;
      random_words = {random_words, w};
   endtask

   task automatic queue_byte(input logic [7:0] c);
      queue_word(c, 1'b0);
   endtask

   // Offer one word, wait for it to be taken and record what it should cause.
   task automatic send_word(input logic [7:0] c, input logic is_end, input logic pinned,
                            input etl_pkg::result_type first_word);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.char_code <= c;
      req_bus.is_end <= is_end;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_word(c, is_end);
      if (pinned) begin
         step_words[0] = first_word;
      end
      expected_words = {expected_words, step_words};
      step_words.delete();
   endtask

   // Result side: random stall bursts; no new burst starts in the closing part of the run.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left <= int'($urandom_range(0, 14));
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Compare every accepted result word with the oldest expectation.
   always @(posedge clock) begin : check_results
      etl_pkg::result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_words.size() == 0) begin
            $error("result word with no expectation waiting: text_byte %0h kind %0d",
                   rsp_bus.text_byte, rsp_bus.token_kind);
            failures++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_bus.text_byte !== want.text_byte) begin
               $error("text_byte: expected %0h, got %0h", want.text_byte, rsp_bus.text_byte);
               failures++;
            end
            if (rsp_bus.has_byte !== want.has_byte) begin
               $error("has_byte: expected %0d, got %0d", want.has_byte, rsp_bus.has_byte);
               failures++;
            end
            if (rsp_bus.token_last !== want.token_last) begin
               $error("token_last: expected %0d, got %0d", want.token_last, rsp_bus.token_last);
               failures++;
            end
            if (rsp_bus.token_kind !== want.token_kind) begin
               $error("token_kind: expected %0d, got %0d", want.token_kind, rsp_bus.token_kind);
               failures++;
            end
            if (rsp_bus.error_code !== want.error_code) begin
               $error("error_code: expected %0d, got %0d", want.error_code, rsp_bus.error_code);
               failures++;
            end
         end
      end
   end

   // Watchdog: too long without any word moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("testbench failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int         n_tokens;
      int         pick;
      int         k;
      logic [7:0] b;
      string      op;
      bit         left_open;

      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.char_code <= 8'h00;
      req_bus.is_end <= 1'b0;

      // Random expressions: mostly well-formed tokens, some noise and broken operators.
      while (random_words.size() < RandomItems) begin
         n_tokens = int'($urandom_range(1, 12));
         left_open = 1'b0;
         for (int t = 0; t < n_tokens && !left_open; t++) begin
            pick = int'($urandom_range(0, 19));
            if (pick <= 3) begin
               queue_byte(random_word_char(1'b1));
               repeat ($urandom_range(0, 5)) queue_byte(random_word_char(1'b0));
            end else if (pick <= 6) begin
               // Integer, integer with a dangling dot, or float.
               repeat ($urandom_range(1, 4)) queue_byte(8'("0" + $urandom_range(0, 9)));
               if (pick >= 5) queue_byte(".");
               if (pick == 6) begin
                  repeat ($urandom_range(1, 3)) queue_byte(8'("0" + $urandom_range(0, 9)));
               end
            end else if (pick <= 8) begin
               queue_byte("\"");
               repeat ($urandom_range(0, 6)) begin
                  if ($urandom_range(0, 3) == 0) begin
                     queue_byte("\\");
                     case ($urandom_range(0, 5))
                        0: queue_byte("n");
                        1: queue_byte("r");
                        2: queue_byte("t");
                        3: queue_byte("\"");
                        4: queue_byte("\\");
                        default: queue_byte(8'($urandom_range(0, 255)));
                     endcase
                  end else begin
                     do b = 8'($urandom_range(0, 255)); while (b == "\"" || b == "\\");
                     queue_byte(b);
                  end
               end
               if ($urandom_range(0, 9) == 0) begin
                  left_open = 1'b1;
               end else begin
                  queue_byte("\"");
               end
            end else if (pick <= 14) begin
               op = op_texts[$urandom_range(0, 25)];
               for (k = 0; k < op.len(); k++) queue_byte(op[k]);
            end else if (pick <= 16) begin
               k = int'($urandom_range(0, 6));
               queue_byte((k == 6) ? 8'h20 : 8'(9 + k));
            end else if (pick == 17) begin
               queue_byte(8'($urandom_range(0, 255)));
            end else if (pick == 18) begin
               op = ":&|";
               queue_byte(op[$urandom_range(0, 2)]);
               queue_byte(8'($urandom_range(0, 255)));
            end else begin
               queue_byte(8'($urandom_range(32, 126)));
            end
            if ($urandom_range(0, 1) == 0) queue_byte(8'h20);
         end
         b = 8'($urandom_range(0, 255));
         queue_word(b, 1'b1);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DirectedCount; i++) begin
         send_word(DirectedRows[i].char_code, DirectedRows[i].is_end,
                   DirectedRows[i].pinned, DirectedRows[i].first_word);
      end
      for (int i = 0; i < random_words.size(); i++) begin
         if (i >= random_words.size() - CalmTail) calm = 1'b1;
         send_word(random_words[i].char_code, random_words[i].is_end, 1'b0, NoWord);
      end
      req_bus.valid <= 1'b0;

      while (expected_words.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (failures == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/etl_pkg.sv
rtl/etl_channels.sv
rtl/etl_step.sv
rtl/etl_out_buf.sv
rtl/expression_token_lexer_top.sv
sim/testbench.sv
